// ----- sv/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional sequential list: request
// codes, status codes and the control word broadcast to the row of cells.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd128;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REM_BACK  = 3'd4,
    ACT_REM_AT    = 3'd5,
    ACT_READ      = 3'd6,
    ACT_NONE      = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // Control word seen by every cell in the same cycle.
  typedef struct packed {
    cell_op_e          op;
    logic              capture;
    logic [CNT_W-1:0]  pos;
  } cell_ctrl_t;

endpackage

// ----- sv/plist_cell.sv -----
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. Takes the new value on an insert at its index, the left neighbor
// on an insert below it, the right neighbor on a remove at or below it, and taps its entry out when selected.
// ----------------------------------------------------------------------------
module plist_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  plist_pkg::cell_ctrl_t         ctrl_i,
  input  logic [plist_pkg::VALUE_W-1:0] ins_value_i,
  input  logic [plist_pkg::VALUE_W-1:0] left_i,
  input  logic [plist_pkg::VALUE_W-1:0] right_i,
  output logic [plist_pkg::VALUE_W-1:0] entry_o,
  output logic [plist_pkg::VALUE_W-1:0] tap_o
);
  import plist_pkg::*;

  logic [VALUE_W-1:0] entry_q, entry_d;
  logic               at_pos, past_pos;

  assign at_pos   = (32'(ctrl_i.pos) == IDX);
  assign past_pos = (32'(ctrl_i.pos) < IDX);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (at_pos) begin
          entry_d = ins_value_i;
        end else if (past_pos) begin
          entry_d = left_i;
        end
      end
      CELL_REM: begin
        if (at_pos || past_pos) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = (ctrl_i.capture && at_pos) ? entry_q : '0;

endmodule

// ----- sv/plist_tree.sv -----
// ----------------------------------------------------------------------------
// plist_tree
// Registered binary OR tree that gathers the one selected cell tap.
// ----------------------------------------------------------------------------
module plist_tree #(
  parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic [plist_pkg::VALUE_W-1:0] leaf_i [CAPACITY],
  output logic [plist_pkg::VALUE_W-1:0] root_o
);
  import plist_pkg::*;

  localparam int unsigned DEPTH  = $clog2(CAPACITY);
  localparam int unsigned LEAVES = 2 ** DEPTH;

  // Heap layout: node k has children 2k and 2k+1, leaves start at LEAVES.
  logic [VALUE_W-1:0] node_q [1:2*LEAVES-1];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < CAPACITY) begin : g_used
      always_ff @(posedge clk_i) begin
        node_q[LEAVES+k] <= leaf_i[k];
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[LEAVES+k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[k] <= node_q[2*k] | node_q[2*k+1];
    end
  end

  assign root_o = node_q[1];

endmodule

// ----- sv/positional_sequential_list.sv -----
// ----------------------------------------------------------------------------
// positional_sequential_list
// Ordered list of 32-bit record handles held in a row of cells. Inserts
// shift later cells up, removes shift them down, all cells in the same cycle.
// ----------------------------------------------------------------------------
// Timing: an insert, a rejected request or an unused code strobes its
//   result in the cycle after the start beat. A good read or remove
//   strobes once its tap has passed the leaf registers and every level
//   of the registered OR tree that collects the selected cell.
// Throughput: a new start beat is taken in the strobe cycle, so inserts run
//   at one per cycle; a good read or remove holds busy_o until its strobe.
// Reset: count clears to zero and list_limit returns to 128; cell contents
//   are not cleared. The receiver cannot stall: done_o lasts one cycle.
// ----------------------------------------------------------------------------
module positional_sequential_list #(
  parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request beat
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [plist_pkg::ACTION_W-1:0] action_i,
  input  logic [plist_pkg::VALUE_W-1:0]  entry_value_i,
  input  logic [plist_pkg::POS_W-1:0]    position_i,
  // list_limit register
  input  logic                           cfg_we_i,
  input  logic [plist_pkg::CNT_W-1:0]    cfg_data_i,
  // result beat
  output logic                           done_o,
  output logic [plist_pkg::STATUS_W-1:0] status_o,
  output logic [plist_pkg::VALUE_W-1:0]  result_value_o,
  output logic [plist_pkg::CNT_W-1:0]    entry_count_o
);
  import plist_pkg::*;

  localparam int unsigned DEPTH  = $clog2(CAPACITY);
  localparam int unsigned WAIT_W = $clog2(DEPTH + 1);

  // Control and register state
  state_e              state_q, state_d;
  logic [WAIT_W-1:0]   wait_q, wait_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    limit_q;
  logic                fetch_q;
  status_e             status_q, status_d;

  // Request decode
  action_e             act;
  logic                accept;
  logic [CNT_W-1:0]    pos_ext, ins_pos, take_pos;
  logic [31:0]         lim_eff;
  logic                is_ins, is_take, is_read;
  cell_op_e            op_d;
  logic                capture_d;
  logic [CNT_W-1:0]    sel_pos;
  cell_ctrl_t          ctrl;

  // Cell row and tree
  logic [VALUE_W-1:0]  entry_w [CAPACITY];
  logic [VALUE_W-1:0]  tap_w   [CAPACITY];
  logic [VALUE_W-1:0]  root_w;

  // Busy only while a tree walk is still in flight; the strobe cycle can
  // take the next beat.
  assign busy_o = (state_q == S_RUN) && (wait_q != '0);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_RUN) && (wait_q == '0);

  assign act      = action_e'(action_i);
  assign pos_ext  = CNT_W'(position_i);
  assign lim_eff  = (32'(limit_q) < CAPACITY) ? 32'(limit_q) : 32'(CAPACITY);
  assign is_ins   = act inside {ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT};
  assign is_take  = act inside {ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT};
  assign is_read  = (act == ACT_READ);

  always_comb begin
    case (act)
      ACT_INS_FRONT: ins_pos = '0;
      ACT_INS_BACK:  ins_pos = count_q;
      default:       ins_pos = pos_ext;
    endcase
    case (act)
      ACT_REM_FRONT: take_pos = '0;
      ACT_REM_BACK:  take_pos = count_q - CNT_W'(1);
      default:       take_pos = pos_ext;
    endcase
  end

  // Check the request against the list and pick the cell operation.
  // Full is tested before position on inserts, empty before position on
  // removes and reads.
  always_comb begin
    status_d  = ST_OK;
    count_d   = count_q;
    op_d      = CELL_HOLD;
    capture_d = 1'b0;
    sel_pos   = '0;
    if (is_ins) begin
      sel_pos = ins_pos;
      if (32'(count_q) >= lim_eff) begin
        status_d = ST_FULL;
      end else if (ins_pos > count_q) begin
        status_d = ST_RANGE;
      end else begin
        op_d    = CELL_INS;
        count_d = count_q + CNT_W'(1);
      end
    end else if (is_take || is_read) begin
      sel_pos = take_pos;
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if (take_pos >= count_q) begin
        status_d = ST_RANGE;
      end else begin
        capture_d = 1'b1;
        if (is_take) begin
          op_d    = CELL_REM;
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  // Drive the broadcast word only on the start beat; hold the row otherwise.
  always_comb begin
    ctrl.pos     = sel_pos;
    ctrl.op      = accept ? op_d : CELL_HOLD;
    ctrl.capture = accept && capture_d;
  end

  // Sequencer: load the wait count with the tree depth for a fetch,
  // drop back to idle after the strobe unless a new beat arrives.
  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          wait_d  = capture_d ? WAIT_W'(DEPTH) : '0;
        end
      end
      S_RUN: begin
        if (wait_q != '0) begin
          wait_d = wait_q - WAIT_W'(1);
        end else if (accept) begin
          wait_d = capture_d ? WAIT_W'(DEPTH) : '0;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        wait_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= '0;
      count_q <= '0;
      limit_q <= LIMIT_RESET;
      fetch_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (accept) begin
        count_q <= count_d;
        fetch_q <= capture_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // Row of cells: each sees its two neighbors; the ends see zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end
    plist_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .ins_value_i (entry_value_i),
      .left_i      (left_w),
      .right_i     (right_w),
      .entry_o     (entry_w[i]),
      .tap_o       (tap_w[i])
    );
  end

  plist_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (tap_w),
    .root_o (root_w)
  );

  // Result beat: value only for a fetch that passed its checks.
  assign status_o       = status_q;
  assign result_value_o = (done_o && fetch_q) ? root_w : '0;
  assign entry_count_o  = count_q;

endmodule

// ----- sv/plist_chk.sv -----
// ----------------------------------------------------------------------------
// plist_chk
// Port-level checks for the positional sequential list, bound to the top.
// ----------------------------------------------------------------------------
module plist_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [plist_pkg::STATUS_W-1:0] status_o,
  input logic [plist_pkg::VALUE_W-1:0]  result_value_o,
  input logic [plist_pkg::CNT_W-1:0]    entry_count_o
);
  import plist_pkg::*;

  // A rejected request returns no handle.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (result_value_o == '0))
    else $error("rejected result carries a nonzero value");

  // Never strobe a result while still walking the tree.
  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result strobe while busy");

  // The count moves only on a start beat.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> $stable(entry_count_o))
    else $error("entry count changed without a request");

  // An empty report goes with an empty list.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with entries present");

  // Every beat taken is followed by a strobe or by busy in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("accepted request left no result in flight");

endmodule

bind positional_sequential_list plist_chk u_plist_chk (.*);
